@@ sv/wkcg_pkg.sv @@
`timescale 1ns / 1ps
package wkcg_pkg;

  localparam int MAX_DIM = 4096;
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 13;
  localparam int SMP_W   = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // Weighted sum 30r+59g+11b, its scaled form times 255, and 100*max.
  localparam int SUM_W   = 23;
  localparam int NUM_W   = 31;
  localparam int DEN_W   = 23;
  localparam int GRAY_W  = 8;
  localparam int QCNT_W  = $clog2(GRAY_W);

  localparam int QDEPTH  = 2;
  localparam int QAW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [IDX_W-1:0] {
    IDX_COL_FIRST    = 3'd0,
    IDX_COL_LAST     = 3'd1,
    IDX_ROW_FIRST    = 3'd2,
    IDX_ROW_LAST     = 3'd3,
    IDX_IMAGE_WIDTH  = 3'd4,
    IDX_IMAGE_HEIGHT = 3'd5,
    IDX_SAMPLE_MAX   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] col_first;
    logic [POS_W-1:0] col_last;
    logic [POS_W-1:0] row_first;
    logic [POS_W-1:0] row_last;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [SMP_W-1:0] sample_max;
  } cfg_t;

  typedef struct packed {
    logic [SMP_W-1:0] red;
    logic [SMP_W-1:0] green;
    logic [SMP_W-1:0] blue;
    logic             keep;
    logic             frame_end;
  } pix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ sv/wkcg_front.sv @@
`timescale 1ns / 1ps
module wkcg_front (
  input  logic             clk,
  input  logic             rst_n,
  input  wkcg_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      red_in,
  input  logic [15:0]      green_in,
  input  logic [15:0]      blue_in,
  input  wkcg_pkg::q_stat_t q_stat,
  output logic             push,
  output wkcg_pkg::pix_t   push_pix
);
  import wkcg_pkg::*;

  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] width_c;
  logic [DIM_W-1:0] height_c;
  logic             keep;
  logic             row_end;
  logic             frame_end;

  // Zero acts as one and anything above the largest frame acts as that size.
  always_comb begin
    if (cfg.image_width == '0) begin
      width_c = DIM_W'(1);
    end else if (cfg.image_width > DIM_W'(MAX_DIM)) begin
      width_c = DIM_W'(MAX_DIM);
    end else begin
      width_c = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      height_c = DIM_W'(1);
    end else if (cfg.image_height > DIM_W'(MAX_DIM)) begin
      height_c = DIM_W'(MAX_DIM);
    end else begin
      height_c = cfg.image_height;
    end
  end

  assign keep = (col_r >= cfg.col_first) && (col_r <= cfg.col_last) &&
                (row_r >= cfg.row_first) && (row_r <= cfg.row_last);
  assign row_end   = (DIM_W'(col_r) + DIM_W'(1)) >= width_c;
  assign frame_end = row_end && ((DIM_W'(row_r) + DIM_W'(1)) >= height_c);

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_pix.red       = red_in;
    push_pix.green     = green_in;
    push_pix.blue      = blue_in;
    push_pix.keep      = keep;
    push_pix.frame_end = frame_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ sv/wkcg_queue.sv @@
`timescale 1ns / 1ps
module wkcg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wkcg_pkg::pix_t    push_pix,
  input  logic              pop,
  output wkcg_pkg::pix_t    head,
  output wkcg_pkg::q_stat_t q_stat
);
  import wkcg_pkg::*;

  pix_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH-1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH-1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pix;
    end
  end

endmodule

@@ sv/wkcg_back.sv @@
`timescale 1ns / 1ps
module wkcg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       sample_max,
  input  wkcg_pkg::pix_t    head,
  input  wkcg_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       red_out,
  output logic [15:0]       green_out,
  output logic [15:0]       blue_out,
  output logic              frame_end
);
  import wkcg_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [SMP_W-1:0]  red_r, green_r, blue_r;
  logic              keep_r;
  logic              fe_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [SMP_W-1:0]  max_c;
  logic [NUM_W-1:0]  num_c;
  logic              sat_c;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsh_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [GRAY_W-1:0] q_r;
  logic [SMP_W-1:0]  gray_c;

  assign max_c   = (sample_max == '0) ? SMP_W'(1) : sample_max;
  assign sum_nxt = SUM_W'(head.red) * SUM_W'(30) + SUM_W'(head.green) * SUM_W'(59) +
                   SUM_W'(head.blue) * SUM_W'(11);
  // Times 255 as a shift and a subtract.
  assign num_c   = {sum_r, 8'b0} - NUM_W'(sum_r);
  // A quotient of 256 or more saturates to full white.
  assign sat_c   = num_c >= {den_r, 8'b0};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = head.keep ? B_OUT : B_PREP;
        end
      end
      B_PREP: state_nxt = sat_c ? B_OUT : B_DIV;
      B_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      B_IDLE:  pop = !q_stat.empty;
      B_OUT:   out_valid = 1'b1;
      default: begin
        pop       = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_PREP) begin
        cnt_r <= QCNT_W'(GRAY_W-1);
      end else if (state_r == B_DIV) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  // Restoring division, one quotient bit per cycle from the top down.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          red_r   <= head.red;
          green_r <= head.green;
          blue_r  <= head.blue;
          keep_r  <= head.keep;
          fe_r    <= head.frame_end;
          sum_r   <= sum_nxt;
          den_r   <= DEN_W'(max_c) * DEN_W'(100);
        end
      end
      B_PREP: begin
        rem_r <= num_c;
        dsh_r <= NUM_W'({den_r, 7'b0});
        q_r   <= sat_c ? '1 : '0;
      end
      B_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r       <= rem_r - dsh_r;
          q_r[cnt_r]  <= 1'b1;
        end
        dsh_r <= dsh_r >> 1;
      end
      default: begin
      end
    endcase
  end

  assign gray_c    = SMP_W'(q_r);
  assign red_out   = keep_r ? red_r   : gray_c;
  assign green_out = keep_r ? green_r : gray_c;
  assign blue_out  = keep_r ? blue_r  : gray_c;
  assign frame_end = fe_r;

  // The partial remainder always stays below twice the current divisor step.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> ({1'b0, rem_r} < {dsh_r, 1'b0}))
    else $error("divider remainder out of range");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r != B_IDLE))
    else $error("item popped but back end stayed idle");

  a_cnt_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == B_DIV) && (cnt_r != '0)) |=>
      ((state_r == B_DIV) && (cnt_r == $past(cnt_r) - QCNT_W'(1))))
    else $error("divider step count broken");

  a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (state_r == B_IDLE))
    else $error("result taken but back end did not return to idle");

endmodule

@@ sv/window_keep_color_grayscale.sv @@
`timescale 1ns / 1ps
// Keeps the color of pixels inside a programmable rectangle and turns every other pixel
// into the weighted gray value floor((30r+59g+11b)*255/(100*max)), saturated at 255 and
// repeated on all three channels; frame_end marks the last pixel of each frame. The front
// end tracks the raster position and can accept one item per cycle while the two-entry
// queue is not full, so input and output stall independently. The back end handles one
// item at a time: a kept pixel is loaded and then output; a gray pixel is loaded, set up,
// run through the restoring divider that produces one quotient bit per cycle, and then
// output, or skips the divider when the gray value saturates. Each output is held until
// out_ready. Configuration must be written while no item is in flight; it takes effect at
// the next item and does not reset the position.
module window_keep_color_grayscale (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out,
  output logic        frame_end
);
  import wkcg_pkg::*;

  cfg_t    cfg_r;
  logic    push;
  pix_t    push_pix;
  logic    pop;
  pix_t    head;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.col_first    <= '0;
      cfg_r.col_last     <= '0;
      cfg_r.row_first    <= '0;
      cfg_r.row_last     <= '0;
      cfg_r.image_width  <= DIM_W'(1);
      cfg_r.image_height <= DIM_W'(1);
      cfg_r.sample_max   <= SMP_W'(255);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        IDX_COL_FIRST:    cfg_r.col_first    <= cfg_wdata[POS_W-1:0];
        IDX_COL_LAST:     cfg_r.col_last     <= cfg_wdata[POS_W-1:0];
        IDX_ROW_FIRST:    cfg_r.row_first    <= cfg_wdata[POS_W-1:0];
        IDX_ROW_LAST:     cfg_r.row_last     <= cfg_wdata[POS_W-1:0];
        IDX_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata[DIM_W-1:0];
        IDX_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata[DIM_W-1:0];
        IDX_SAMPLE_MAX:   cfg_r.sample_max   <= cfg_wdata[SMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wkcg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .q_stat   (q_stat),
    .push     (push),
    .push_pix (push_pix)
  );

  wkcg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pix (push_pix),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  wkcg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .sample_max (cfg_r.sample_max),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_end  (frame_end)
  );

endmodule
